FILE: rtl/core/point_in_mesh_ray_parity_assert.svh
// Assertion macros shared by the checker file.
`ifndef POINT_IN_MESH_RAY_PARITY_ASSERT_SVH
`define POINT_IN_MESH_RAY_PARITY_ASSERT_SVH

// Clocked assertion, masked while reset is applied.
`define PIMRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PIMRP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/pimrp_pkg.sv
`timescale 1ns / 1ps

package pimrp_pkg;

  // Command codes of an input beat
  localparam logic CMD_POINT  = 1'b0;
  localparam logic CMD_CORNER = 1'b1;

  // Width of the crossing total on the result beat
  localparam int TOTAL_W = 17;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;   // update the accumulator
    logic clr;  // start from zero instead of the held sum
    logic neg;  // subtract the product
    logic hi;   // weight the product by the upper-half shift
  } mac_ctrl_t;

endpackage

FILE: rtl/core/pimrp_if.sv
`timescale 1ns / 1ps

// Input channel: query points and triangle corners
interface pimrp_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         final_item;

  modport source (output valid, cmd, coord_x, coord_y, coord_z, final_item, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, coord_z, final_item, output ready);
endinterface

// Result channel: parity, crossing total and leftover flag
interface pimrp_out_if;
  logic        valid;
  logic        ready;
  logic        inside_res;
  logic [16:0] crossing_total;
  logic        partial_triangle;

  modport source (output valid, inside_res, crossing_total, partial_triangle, input ready);
  modport sink   (input valid, inside_res, crossing_total, partial_triangle, output ready);
endinterface

FILE: rtl/core/point_in_mesh_ray_parity.sv
`timescale 1ns / 1ps
// Point-in-mesh test by vertical ray-crossing parity.
// in_i carries beats: cmd=0 sets the query point and clears the count,
// cmd=1 is one triangle corner, three corners per triangle. A beat with
// final_item=1 closes the query and yields one result beat on out_o:
// inside_res (count odd), crossing_total (saturating at MAX_FACES) and
// partial_triangle (one or two corners left over).
// Query points and first or second corners need no sequence. A third
// corner runs a 17-step sequence through one shared multiply-accumulate
// unit (normal, plane side, two barycentric terms), so in_i is not ready
// until the sequence ends; a result caused by it is loaded at its last
// step, other results in the cycle after the beat.
// The result sits in an output register; a new beat is taken while it
// waits only when out_o.ready is high in that cycle, so a stalled receiver
// holds the block once the register is full.
// Reset clears the query point, the count, the corner phase and the
// result valid flag; the result payload is not reset.
module point_in_mesh_ray_parity #(
  parameter int COORD_BITS = 24,
  parameter int MAX_FACES  = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pimrp_in_if.sink    in_i,
  pimrp_out_if.source out_o
);
  import pimrp_pkg::*;

  localparam int DW        = COORD_BITS + 1;
  localparam int MW        = DW + 2;
  localparam int NW        = 2 * DW + 1;
  localparam int AW        = 3 * DW + 4;
  localparam int CW        = $clog2(MAX_FACES + 1);
  localparam int LAST_STEP = 16;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic                          state_q;
  logic [4:0]                    step_q;
  logic [1:0]                    phase_q;
  logic [CW-1:0]                 cnt_q;
  logic                          fin_q;
  logic                          ov_q;

  logic signed [COORD_BITS-1:0]  qp_q [3];
  logic signed [COORD_BITS-1:0]  held_q [2][3];
  logic signed [DW-1:0]          ux_q, uy_q, uz_q, vx_q, vy_q, vz_q, wx_q, wy_q, wz_q;
  logic signed [NW-1:0]          nx_q, ny_q, nz_q;
  logic signed [AW-1:0]          a_q, s_q;

  logic                          in_ready;
  logic                          in_acc;
  logic                          out_fire;
  logic signed [COORD_BITS-1:0]  cin [3];

  mac_ctrl_t                     mac_ctrl;
  logic signed [MW-1:0]          op_a, op_b;
  logic signed [AW-1:0]          acc;

  logic signed [AW-1:0]          ny_w, dn, sn, tn, rem;
  logic                          hit;
  logic                          cnt_inc;
  logic [CW-1:0]                 cnt_next;
  logic [CW+16:0]                cnt_ext;

  logic                          res_ld;
  logic [CW-1:0]                 res_cnt;
  logic                          res_part;
  logic                          inside_q, partial_q;
  logic [TOTAL_W-1:0]            total_q;

  assign cin[0] = in_i.coord_x;
  assign cin[1] = in_i.coord_y;
  assign cin[2] = in_i.coord_z;

  // Handshake
  assign in_ready   = (state_q == ST_IDLE) && (!ov_q || out_o.ready);
  assign in_acc     = in_i.valid && in_ready;
  assign out_fire   = ov_q && out_o.ready;
  assign in_i.ready = in_ready;

  // Sequence the shared unit's operands
  always_comb begin
    mac_ctrl = '0;
    op_a     = '0;
    op_b     = '0;
    if (state_q == ST_CALC) begin
      unique case (step_q)
        5'd0:  begin op_a = MW'(uy_q); op_b = MW'(vz_q); mac_ctrl = '{1'b1, 1'b1, 1'b0, 1'b0}; end
        5'd1:  begin op_a = MW'(uz_q); op_b = MW'(vy_q); mac_ctrl = '{1'b1, 1'b0, 1'b1, 1'b0}; end
        5'd2:  begin op_a = MW'(uz_q); op_b = MW'(vx_q); mac_ctrl = '{1'b1, 1'b1, 1'b0, 1'b0}; end
        5'd3:  begin op_a = MW'(ux_q); op_b = MW'(vz_q); mac_ctrl = '{1'b1, 1'b0, 1'b1, 1'b0}; end
        5'd4:  begin op_a = MW'(ux_q); op_b = MW'(vy_q); mac_ctrl = '{1'b1, 1'b1, 1'b0, 1'b0}; end
        5'd5:  begin op_a = MW'(uy_q); op_b = MW'(vx_q); mac_ctrl = '{1'b1, 1'b0, 1'b1, 1'b0}; end
        5'd6:  begin
          op_a = $signed(MW'({1'b0, nx_q[DW-1:0]})); op_b = MW'(wx_q);
          mac_ctrl = '{1'b1, 1'b1, 1'b0, 1'b0};
        end
        5'd7:  begin
          op_a = MW'($signed(nx_q[NW-1:DW])); op_b = MW'(wx_q);
          mac_ctrl = '{1'b1, 1'b0, 1'b0, 1'b1};
        end
        5'd8:  begin
          op_a = $signed(MW'({1'b0, ny_q[DW-1:0]})); op_b = MW'(wy_q);
          mac_ctrl = '{1'b1, 1'b0, 1'b0, 1'b0};
        end
        5'd9:  begin
          op_a = MW'($signed(ny_q[NW-1:DW])); op_b = MW'(wy_q);
          mac_ctrl = '{1'b1, 1'b0, 1'b0, 1'b1};
        end
        5'd10: begin
          op_a = $signed(MW'({1'b0, nz_q[DW-1:0]})); op_b = MW'(wz_q);
          mac_ctrl = '{1'b1, 1'b0, 1'b0, 1'b0};
        end
        5'd11: begin
          op_a = MW'($signed(nz_q[NW-1:DW])); op_b = MW'(wz_q);
          mac_ctrl = '{1'b1, 1'b0, 1'b0, 1'b1};
        end
        5'd12: begin op_a = MW'(wz_q); op_b = MW'(vx_q); mac_ctrl = '{1'b1, 1'b1, 1'b0, 1'b0}; end
        5'd13: begin op_a = MW'(wx_q); op_b = MW'(vz_q); mac_ctrl = '{1'b1, 1'b0, 1'b1, 1'b0}; end
        5'd14: begin op_a = MW'(uz_q); op_b = MW'(wx_q); mac_ctrl = '{1'b1, 1'b1, 1'b0, 1'b0}; end
        5'd15: begin op_a = MW'(ux_q); op_b = MW'(wz_q); mac_ctrl = '{1'b1, 1'b0, 1'b1, 1'b0}; end
        default: begin mac_ctrl = '0; end
      endcase
    end
  end

  pimrp_mac #(
    .MW    (MW),
    .AW    (AW),
    .SHIFT (DW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (op_a),
    .b_i    (op_b),
    .acc_o  (acc)
  );

  // Decide the crossing from normal, plane side and barycentric terms
  always_comb begin
    ny_w = AW'(ny_q);
    if (!ny_q[NW-1]) begin
      dn = ny_w;
      sn = -s_q;
      tn = -acc;
    end else begin
      dn = -ny_w;
      sn = s_q;
      tn = acc;
    end
    rem = dn - sn - tn;
    hit = (ny_q != '0) &&
          !((a_q != '0) && (a_q[AW-1] != ny_q[NW-1])) &&
          !sn[AW-1] && !tn[AW-1] && !rem[AW-1];
    cnt_inc  = hit && (cnt_q < CW'(MAX_FACES));
    cnt_next = cnt_inc ? cnt_q + CW'(1) : cnt_q;
  end

  // Result of the current beat or of the finished sequence
  always_comb begin
    res_ld   = 1'b0;
    res_cnt  = cnt_q;
    res_part = 1'b0;
    if (in_acc && in_i.final_item) begin
      if (in_i.cmd == CMD_POINT) begin
        res_ld  = 1'b1;
        res_cnt = '0;
      end else if (phase_q != 2'd2) begin
        res_ld   = 1'b1;
        res_part = 1'b1;
      end
    end
    if ((state_q == ST_CALC) && (step_q == 5'(LAST_STEP)) && fin_q) begin
      res_ld  = 1'b1;
      res_cnt = cnt_next;
    end
  end

  assign cnt_ext = {17'b0, res_cnt};

  // Control: state, step, phase, count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      phase_q <= '0;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (out_fire) begin
        ov_q <= 1'b0;
      end
      if (res_ld) begin
        ov_q <= 1'b1;
      end
      if (in_acc) begin
        if (in_i.cmd == CMD_POINT) begin
          phase_q <= '0;
          cnt_q   <= '0;
        end else if (phase_q != 2'd2) begin
          phase_q <= in_i.final_item ? 2'd0 : phase_q + 2'd1;
          if (in_i.final_item) begin
            cnt_q <= '0;
          end
        end else begin
          phase_q <= '0;
          state_q <= ST_CALC;
          step_q  <= '0;
          fin_q   <= in_i.final_item;
        end
      end
      if (state_q == ST_CALC) begin
        if (step_q == 5'(LAST_STEP)) begin
          state_q <= ST_IDLE;
          cnt_q   <= fin_q ? '0 : cnt_next;
        end else begin
          step_q <= step_q + 5'd1;
        end
      end
    end
  end

  // Hold the query point; reset clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        qp_q[k] <= '0;
      end
    end else if (in_acc && (in_i.cmd == CMD_POINT)) begin
      for (int k = 0; k < 3; k++) begin
        qp_q[k] <= cin[k];
      end
    end
  end

  // Datapath: corners, differences, captured sums and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_i.cmd == CMD_CORNER)) begin
      if (phase_q != 2'd2) begin
        for (int k = 0; k < 3; k++) begin
          held_q[phase_q[0]][k] <= cin[k];
        end
      end else begin
        ux_q <= DW'(held_q[1][0]) - DW'(held_q[0][0]);
        uy_q <= DW'(held_q[1][1]) - DW'(held_q[0][1]);
        uz_q <= DW'(held_q[1][2]) - DW'(held_q[0][2]);
        vx_q <= DW'(cin[0]) - DW'(held_q[0][0]);
        vy_q <= DW'(cin[1]) - DW'(held_q[0][1]);
        vz_q <= DW'(cin[2]) - DW'(held_q[0][2]);
        wx_q <= DW'(held_q[0][0]) - DW'(qp_q[0]);
        wy_q <= DW'(held_q[0][1]) - DW'(qp_q[1]);
        wz_q <= DW'(held_q[0][2]) - DW'(qp_q[2]);
      end
    end
    if (state_q == ST_CALC) begin
      unique case (step_q)
        5'd2:    nx_q <= NW'(acc);
        5'd4:    ny_q <= NW'(acc);
        5'd6:    nz_q <= NW'(acc);
        5'd12:   a_q  <= acc;
        5'd14:   s_q  <= acc;
        default: ;
      endcase
    end
    if (res_ld) begin
      inside_q  <= res_cnt[0];
      total_q   <= cnt_ext[TOTAL_W-1:0];
      partial_q <= res_part;
    end
  end

  assign out_o.valid            = ov_q;
  assign out_o.inside_res       = inside_q;
  assign out_o.crossing_total   = total_q;
  assign out_o.partial_triangle = partial_q;

endmodule

FILE: rtl/core/pimrp_mac.sv
`timescale 1ns / 1ps

module pimrp_mac #(
  parameter int MW    = 27,
  parameter int AW    = 79,
  parameter int SHIFT = 25
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pimrp_pkg::mac_ctrl_t    ctrl_i,
  input  logic signed [MW-1:0]    a_i,
  input  logic signed [MW-1:0]    b_i,
  output logic signed [AW-1:0]    acc_o
);
  import pimrp_pkg::*;

  logic signed [2*MW-1:0] prod;
  logic signed [AW-1:0]   term;
  logic signed [AW-1:0]   base;
  logic signed [AW-1:0]   acc_d;
  logic signed [AW-1:0]   acc_q;

  // Multiply, weight, sign and add into the running sum
  always_comb begin
    prod  = a_i * b_i;
    term  = AW'(prod);
    if (ctrl_i.hi) begin
      term = term <<< SHIFT;
    end
    if (ctrl_i.neg) begin
      term = -term;
    end
    base  = ctrl_i.clr ? '0 : acc_q;
    acc_d = base + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/core/pimrp_checker.sv
`timescale 1ns / 1ps
`include "point_in_mesh_ray_parity_assert.svh"

module pimrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_cmd_i,
  input logic        in_final_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_inside_i,
  input logic [16:0] out_total_i,
  input logic        out_partial_i
);
  import pimrp_pkg::*;

  logic out_stall;
  logic point_close;
  logic zero_res;

  assign out_stall   = out_valid_i && !out_ready_i;
  assign point_close = in_valid_i && in_ready_i && (in_cmd_i == CMD_POINT) && in_final_i;
  assign zero_res    = (out_total_i == 17'd0) && !out_inside_i && !out_partial_i;

  // Result beat held until taken
  `PIMRP_ASSERT(a_out_hold, out_stall |=> out_valid_i, "result beat dropped")

  // Stalled result keeps its total and partial flag
  `PIMRP_ASSERT(a_out_stable, out_stall |=> $stable(out_total_i) && $stable(out_partial_i), "stalled result changed")

  // Closing query point answers at once with zeros
  `PIMRP_ASSERT(a_point_final, point_close |=> out_valid_i && zero_res, "bad answer to closing point")

  // Parity agrees with the total
  `PIMRP_ASSERT(a_parity, out_valid_i |-> (out_inside_i == out_total_i[0]), "parity mismatch")

  // No result while reset has been applied
  `PIMRP_ASSERT_RST(a_rst_quiet, !rst_ni |=> !out_valid_i, "result valid in reset")

endmodule

bind point_in_mesh_ray_parity pimrp_checker u_pimrp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_cmd_i      (in_i.cmd),
  .in_final_i    (in_i.final_item),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_inside_i  (out_o.inside_res),
  .out_total_i   (out_o.crossing_total),
  .out_partial_i (out_o.partial_triangle)
);
